// ===== sv/set_union_intersection_difference_macros.svh =====
// Assertion macros shared by the checker of the set union, intersection and difference block.
`ifndef SET_UNION_INTERSECTION_DIFFERENCE_MACROS_SVH
`define SET_UNION_INTERSECTION_DIFFERENCE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SUD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SUD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sud_pkg.sv =====
// Package with the types, sizes and codes of the set union, intersection and difference block.
package sud_pkg;

   localparam int SET_DEPTH     = 16;
   localparam int ELEMENT_WIDTH = 32;
   localparam int IDX_W         = $clog2(SET_DEPTH);
   localparam int CNT_W         = $clog2(SET_DEPTH + 1);
   localparam int WORD_W        = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   typedef logic signed [ELEMENT_WIDTH-1:0] elem_type;
   typedef logic signed [WORD_W-1:0]        word_type;
   typedef logic [IDX_W-1:0]                idx_type;
   typedef logic [CNT_W-1:0]                cnt_type;

   typedef enum logic [1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_COMPUTE = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   localparam logic [1:0] OP_UNION      = 2'd0;
   localparam logic [1:0] OP_INTERSECT  = 2'd1;
   localparam logic [1:0] OP_DIFFERENCE = 2'd2;

   localparam logic [0:0] REG_SET_OPERATION = 1'b0;

   typedef struct packed {
      logic    shift;
      logic    write;
      idx_type write_index;
   } ring_ctrl_type;

endpackage

// ===== sv/sud_req_if.sv =====
// Request channel interface: action and value beats into the block.
interface sud_req_if;
   logic                  valid;
   logic                  ready;
   logic [1:0]            action;
   logic signed [31:0]    value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

// ===== sv/sud_rsp_if.sv =====
// Response channel interface: result element beats out of the block.
interface sud_rsp_if;
   logic                  valid;
   logic                  ready;
   logic signed [31:0]    result_value;
   logic                  present;
   logic                  last;
   logic                  overflowed;

   modport source (output valid, output result_value, output present, output last,
                   output overflowed, input ready);
   modport sink (input valid, input result_value, input present, input last,
                 input overflowed, output ready);
endinterface

// ===== sv/sud_cell.sv =====
// One storage cell of a set ring: holds an element, takes its neighbor's on a shift.
module sud_cell (
   input  logic              clock,
   input  logic              shift,
   input  logic              write,
   input  sud_pkg::elem_type write_data,
   input  sud_pkg::elem_type next_data,
   output sud_pkg::elem_type data
);

   sud_pkg::elem_type data_ff;
   sud_pkg::elem_type data_in;

   always_comb begin
      data_in = data_ff;
      if (write) begin
         data_in = write_data;
      end else if (shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== sv/sud_ring.sv =====
// Ring of cells holding one set; a shift rotates every element one place toward the head.
module sud_ring (
   input  logic                   clock,
   input  sud_pkg::ring_ctrl_type ctrl,
   input  sud_pkg::elem_type      write_data,
   output sud_pkg::elem_type      head
);

   sud_pkg::elem_type cell_data [sud_pkg::SET_DEPTH];

   for (genvar g = 0; g < sud_pkg::SET_DEPTH; g++) begin : g_cell
      logic cell_write;

      assign cell_write = ctrl.write && (ctrl.write_index == sud_pkg::idx_type'(g));

      sud_cell u_cell (
         .clock      (clock),
         .shift      (ctrl.shift),
         .write      (cell_write),
         .write_data (write_data),
         .next_data  (cell_data[(g + 1) % sud_pkg::SET_DEPTH]),
         .data       (cell_data[g])
      );
   end

   assign head = cell_data[0];

endmodule

// ===== sv/set_union_intersection_difference.sv =====
// Top level of the set union, intersection and difference block.
//
// Request beats carry an action and a value: load A, load B, compute or clear.
// A load appends the value to its set unless it is already a member; a load
// into a full set that is not a match is dropped and sets the sticky overflow
// flag. Clear empties both sets. A compute emits the result that
// the set_operation CSR selects as a burst of response beats, the final one
// marked last; an empty result is one beat with present low and last high.
// Each set is a ring of SET_DEPTH cells; every membership search is one full
// rotation, one cell per cycle. A compute runs one full inner ring rotation
// for each outer element; a union first walks A once to emit its members.
// The response side has an output register plus one pending element; when
// both hold a beat and another element is produced while the receiver
// stalls, the rings hold position until the beat is taken.
// Reset empties both sets, clears the overflow flag and selects union.
module set_union_intersection_difference (
   input  logic                                clock,
   input  logic                                reset,
   sud_req_if.sink                             req_ch,
   sud_rsp_if.source                           rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sud_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sud_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sud_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD_SCAN,
      S_APPEND,
      S_EMIT_A,
      S_SCAN,
      S_DECIDE,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   sud_pkg::idx_type  step_ff, step_in;
   sud_pkg::idx_type  outer_idx_ff, outer_idx_in;
   logic              found_ff, found_in;
   logic              inner_b_ff, inner_b_in;
   logic              want_ff, want_in;
   sud_pkg::elem_type key_ff, key_in;
   sud_pkg::cnt_type  cnt_a_ff, cnt_a_in;
   sud_pkg::cnt_type  cnt_b_ff, cnt_b_in;
   logic              ovf_ff, ovf_in;
   logic [1:0]        op_ff, op_in;
   logic              pend_valid_ff, pend_valid_in;
   sud_pkg::elem_type pend_value_ff, pend_value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sud_pkg::elem_type rsp_value_ff, rsp_value_in;
   logic              rsp_present_ff, rsp_present_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   sud_pkg::elem_type      head_a, head_b, inner_head, outer_head;
   sud_pkg::cnt_type       inner_cnt, outer_cnt;
   sud_pkg::ring_ctrl_type ctrl_a, ctrl_b;
   logic                   step_last, outer_last, can_emit, stall;
   logic                   shift_inner, shift_outer, shift_a_only, write_inner;
   logic                   produce_req, out_load, out_present, out_last;
   sud_pkg::elem_type      produce_val, out_value;
   logic                   csr_write;

   sud_ring u_ring_a (
      .clock      (clock),
      .ctrl       (ctrl_a),
      .write_data (key_ff),
      .head       (head_a)
   );

   sud_ring u_ring_b (
      .clock      (clock),
      .ctrl       (ctrl_b),
      .write_data (key_ff),
      .head       (head_b)
   );

   assign inner_head = inner_b_ff ? head_b : head_a;
   assign outer_head = inner_b_ff ? head_a : head_b;
   assign inner_cnt  = inner_b_ff ? cnt_b_ff : cnt_a_ff;
   assign outer_cnt  = inner_b_ff ? cnt_a_ff : cnt_b_ff;
   assign step_last  = step_ff == sud_pkg::idx_type'(sud_pkg::SET_DEPTH - 1);
   assign outer_last = outer_idx_ff == sud_pkg::idx_type'(sud_pkg::SET_DEPTH - 1);
   assign can_emit   = !rsp_valid_ff || rsp_ch.ready;
   assign stall      = produce_req && pend_valid_ff && !can_emit;

   always_comb begin
      ctrl_a.shift       = shift_a_only || (shift_inner && !inner_b_ff) ||
                           (shift_outer && inner_b_ff);
      ctrl_b.shift       = (shift_inner && inner_b_ff) || (shift_outer && !inner_b_ff);
      ctrl_a.write       = write_inner && !inner_b_ff;
      ctrl_b.write       = write_inner && inner_b_ff;
      ctrl_a.write_index = inner_cnt[sud_pkg::IDX_W-1:0];
      ctrl_b.write_index = inner_cnt[sud_pkg::IDX_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      outer_idx_in  = outer_idx_ff;
      found_in      = found_ff;
      inner_b_in    = inner_b_ff;
      want_in       = want_ff;
      key_in        = key_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      ovf_in        = ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      shift_inner   = 1'b0;
      shift_outer   = 1'b0;
      shift_a_only  = 1'b0;
      write_inner   = 1'b0;
      produce_req   = 1'b0;
      produce_val   = outer_head;
      out_load      = 1'b0;
      out_value     = pend_value_ff;
      out_present   = 1'b1;
      out_last      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               step_in      = '0;
               outer_idx_in = '0;
               found_in     = 1'b0;
               case (sud_pkg::action_type'(req_ch.action))
                  sud_pkg::ACT_LOAD_A: begin
                     key_in     = sud_pkg::elem_type'(req_ch.value);
                     inner_b_in = 1'b0;
                     state_in   = S_LOAD_SCAN;
                  end
                  sud_pkg::ACT_LOAD_B: begin
                     key_in     = sud_pkg::elem_type'(req_ch.value);
                     inner_b_in = 1'b1;
                     state_in   = S_LOAD_SCAN;
                  end
                  sud_pkg::ACT_COMPUTE: begin
                     pend_valid_in = 1'b0;
                     case (op_ff)
                        sud_pkg::OP_UNION: begin
                           state_in = S_EMIT_A;
                        end
                        sud_pkg::OP_INTERSECT: begin
                           inner_b_in = 1'b1;
                           want_in    = 1'b1;
                           state_in   = S_SCAN;
                        end
                        sud_pkg::OP_DIFFERENCE: begin
                           inner_b_in = 1'b1;
                           want_in    = 1'b0;
                           state_in   = S_SCAN;
                        end
                        default: begin
                           state_in = S_FINISH;
                        end
                     endcase
                  end
                  sud_pkg::ACT_CLEAR: begin
                     cnt_a_in = '0;
                     cnt_b_in = '0;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_LOAD_SCAN: begin
            if ((sud_pkg::cnt_type'(step_ff) < inner_cnt) && (inner_head == key_ff)) begin
               found_in = 1'b1;
            end
            shift_inner = 1'b1;
            if (step_last) begin
               step_in  = '0;
               state_in = S_APPEND;
            end else begin
               step_in = step_ff + sud_pkg::idx_type'(1);
            end
         end
         S_APPEND: begin
            if (!found_ff) begin
               if (inner_cnt < sud_pkg::cnt_type'(sud_pkg::SET_DEPTH)) begin
                  write_inner = 1'b1;
                  if (inner_b_ff) begin
                     cnt_b_in = cnt_b_ff + sud_pkg::cnt_type'(1);
                  end else begin
                     cnt_a_in = cnt_a_ff + sud_pkg::cnt_type'(1);
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            state_in = S_IDLE;
         end
         S_EMIT_A: begin
            if (sud_pkg::cnt_type'(step_ff) < cnt_a_ff) begin
               produce_req = 1'b1;
               produce_val = head_a;
            end
            if (!stall) begin
               shift_a_only = 1'b1;
               if (step_last) begin
                  step_in      = '0;
                  inner_b_in   = 1'b0;
                  want_in      = 1'b0;
                  outer_idx_in = '0;
                  found_in     = 1'b0;
                  state_in     = S_SCAN;
               end else begin
                  step_in = step_ff + sud_pkg::idx_type'(1);
               end
            end
         end
         S_SCAN: begin
            if (sud_pkg::cnt_type'(outer_idx_ff) >= outer_cnt) begin
               shift_outer = 1'b1;
               if (outer_last) begin
                  outer_idx_in = '0;
                  state_in     = S_FINISH;
               end else begin
                  outer_idx_in = outer_idx_ff + sud_pkg::idx_type'(1);
               end
            end else begin
               if ((sud_pkg::cnt_type'(step_ff) < inner_cnt) &&
                   (inner_head == outer_head)) begin
                  found_in = 1'b1;
               end
               shift_inner = 1'b1;
               if (step_last) begin
                  step_in  = '0;
                  state_in = S_DECIDE;
               end else begin
                  step_in = step_ff + sud_pkg::idx_type'(1);
               end
            end
         end
         S_DECIDE: begin
            if (found_ff == want_ff) begin
               produce_req = 1'b1;
               produce_val = outer_head;
            end
            if (!stall) begin
               shift_outer = 1'b1;
               found_in    = 1'b0;
               if (outer_last) begin
                  outer_idx_in = '0;
                  state_in     = S_FINISH;
               end else begin
                  outer_idx_in = outer_idx_ff + sud_pkg::idx_type'(1);
                  state_in     = S_SCAN;
               end
            end
         end
         S_FINISH: begin
            if (can_emit) begin
               out_load      = 1'b1;
               out_value     = pend_valid_ff ? pend_value_ff : '0;
               out_present   = pend_valid_ff;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (produce_req && !stall) begin
         if (pend_valid_ff) begin
            out_load    = 1'b1;
            out_value   = pend_value_ff;
            out_present = 1'b1;
            out_last    = 1'b0;
         end
         pend_value_in = produce_val;
         pend_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = out_value;
         rsp_present_in = out_present;
         rsp_last_in    = out_last;
         rsp_ovf_in     = ovf_ff;
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      op_in = op_ff;
      if (csr_write && (csr_paddr[2:2] == sud_pkg::REG_SET_OPERATION)) begin
         op_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      outer_idx_ff   <= outer_idx_in;
      found_ff       <= found_in;
      inner_b_ff     <= inner_b_in;
      want_ff        <= want_in;
      key_ff         <= key_in;
      pend_value_ff  <= pend_value_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         ovf_ff        <= 1'b0;
         op_ff         <= sud_pkg::OP_UNION;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         ovf_ff        <= ovf_in;
         op_ff         <= op_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_ch.ready        = state_ff == S_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = sud_pkg::word_type'(rsp_value_ff);
   assign rsp_ch.present      = rsp_present_ff;
   assign rsp_ch.last         = rsp_last_ff;
   assign rsp_ch.overflowed   = rsp_ovf_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:2] == sud_pkg::REG_SET_OPERATION) ?
                       sud_pkg::CSR_DATA_W'(op_ff) : '0;

endmodule

// ===== sv/sud_checker.sv =====
// Port-level checker for the set union, intersection and difference block, with its bind.
`include "set_union_intersection_difference_macros.svh"

module sud_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_value,
   input logic        rsp_present,
   input logic        rsp_last,
   input logic        rsp_overflowed
);

   logic [1:0] open_ff, open_in;
   logic       seen_ovf_ff, seen_ovf_in;
   logic       compute_beat, last_beat;

   assign compute_beat = req_valid && req_ready && (req_action == sud_pkg::ACT_COMPUTE);
   assign last_beat    = rsp_valid && rsp_ready && rsp_last;

   always_comb begin
      open_in = open_ff;
      if (compute_beat && !last_beat) begin
         open_in = open_ff + 2'd1;
      end else if (!compute_beat && last_beat) begin
         open_in = open_ff - 2'd1;
      end
      seen_ovf_in = seen_ovf_ff || (rsp_valid && rsp_overflowed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 2'd0;
         seen_ovf_ff <= 1'b0;
      end else begin
         open_ff     <= open_in;
         seen_ovf_ff <= seen_ovf_in;
      end
   end

   `SUD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_present) && $stable(rsp_last) && $stable(rsp_overflowed), "Stalled response beat changed.")
   `SUD_ASSERT_IMP(a_empty_is_last, clock, reset, rsp_valid && !rsp_present, rsp_last && (rsp_result_value == 32'd0), "Empty result beat is not a lone last beat with value zero.")
   `SUD_ASSERT_IMP(a_ovf_sticky, clock, reset, rsp_valid && seen_ovf_ff, rsp_overflowed, "Overflow flag fell without reset.")
   `SUD_ASSERT_IMP(a_rsp_needs_compute, clock, reset, rsp_valid, open_ff != 2'd0, "Response beat without an open compute.")

endmodule

bind set_union_intersection_difference sud_checker u_sud_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_action       (req_ch.action),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_present      (rsp_ch.present),
   .rsp_last         (rsp_ch.last),
   .rsp_overflowed   (rsp_ch.overflowed)
);

// ===== verif/set_union_intersection_difference_tb.sv =====
// Self-checking testbench of the set union, intersection and difference block.
`timescale 1ns / 100ps

module set_union_intersection_difference_tb;

   localparam int SETTLE_CYCLES = sud_pkg::SET_DEPTH +
                                  sud_pkg::SET_DEPTH * (sud_pkg::SET_DEPTH + 1) + 16;
   localparam int HOLD_CYCLES   = 800;
   localparam int IDLE_LIMIT    = 5000;
   localparam int RANDOM_ITEMS  = 130;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [sud_pkg::CSR_ADDR_W-1:0] SET_OPERATION_ADDR =
      sud_pkg::CSR_ADDR_W'(4 * sud_pkg::REG_SET_OPERATION);

   typedef struct packed {
      sud_pkg::word_type value;
      logic              present;
      logic              last;
      logic              overflowed;
   } element_beat_type;

   typedef enum {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [sud_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [sud_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [sud_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   sud_req_if req ();
   sud_rsp_if rsp ();

   set_union_intersection_difference dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sud_pkg::elem_type set_a [sud_pkg::SET_DEPTH];
   sud_pkg::elem_type set_b [sud_pkg::SET_DEPTH];
   int                size_a = 0;
   int                size_b = 0;
   logic              drop_flag = 1'b0;
   logic [1:0]        op_sel = sud_pkg::OP_UNION;
   element_beat_type  expected_beats [$];
   int                mismatches = 0;
   int                items_sent = 0;
   int                burst_left = 0;
   int                holds_asked = 0;
   int                holds_done = 0;
   int                hold_left = 0;
   int                mode_left = 0;
   rx_mode_type       rx_mode = RX_STEADY;
   int                idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit holds(input sud_pkg::elem_type members [sud_pkg::SET_DEPTH],
                                input int size, input sud_pkg::elem_type v);
      for (int i = 0; i < size; i++) begin
         if (members[i] == v) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void add_member(ref sud_pkg::elem_type members [sud_pkg::SET_DEPTH],
                                      ref int size, input sud_pkg::elem_type v);
      if (holds(members, size, v)) return;
      if (size >= sud_pkg::SET_DEPTH) begin
         drop_flag = 1'b1;
         return;
      end
      members[size] = v;
      size++;
   endfunction

   function automatic void push_beat(input sud_pkg::word_type v, input logic present);
      element_beat_type beat;
      beat.value      = v;
      beat.present    = present;
      beat.last       = 1'b0;
      beat.overflowed = drop_flag;
      expected_beats  = {expected_beats, beat};
   endfunction

   function automatic void predict_request(input sud_pkg::action_type act,
                                           input sud_pkg::word_type value);
      sud_pkg::elem_type v;
      int                first;
      v = sud_pkg::elem_type'(value);
      case (act)
         sud_pkg::ACT_LOAD_A: add_member(set_a, size_a, v);
         sud_pkg::ACT_LOAD_B: add_member(set_b, size_b, v);
         sud_pkg::ACT_CLEAR: begin
            size_a = 0;
            size_b = 0;
         end
         default: begin
            first = expected_beats.size();
            case (op_sel)
               sud_pkg::OP_UNION: begin
                  for (int i = 0; i < size_a; i++)
                     push_beat(sud_pkg::word_type'(set_a[i]), 1'b1);
                  for (int i = 0; i < size_b; i++) begin
                     if (!holds(set_a, size_a, set_b[i]))
                        push_beat(sud_pkg::word_type'(set_b[i]), 1'b1);
                  end
               end
               sud_pkg::OP_INTERSECT, sud_pkg::OP_DIFFERENCE: begin
                  for (int i = 0; i < size_a; i++) begin
                     if (holds(set_b, size_b, set_a[i]) == (op_sel == sud_pkg::OP_INTERSECT))
                        push_beat(sud_pkg::word_type'(set_a[i]), 1'b1);
                  end
               end
               default: ;
            endcase
            if (expected_beats.size() == first) push_beat('0, 1'b0);
            expected_beats[expected_beats.size() - 1].last = 1'b1;
         end
      endcase
   endfunction

   function automatic sud_pkg::word_type random_word();
      case ($urandom_range(0, 9))
         0: return sud_pkg::word_type'(32'h8000_0000);
         1: return sud_pkg::word_type'(32'h7fff_ffff);
         2: return '0;
         3: return '1;
         default: return sud_pkg::word_type'($urandom);
      endcase
   endfunction

   task automatic send_item(input sud_pkg::action_type act, input sud_pkg::word_type value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req.valid  <= 1'b1;
      req.action <= act;
      req.value  <= value;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_request(act, value);
      burst_left--;
      items_sent++;
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic change_operation(input logic [1:0] op);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SET_OPERATION_ADDR;
      csr_pwdata  <= sud_pkg::CSR_DATA_W'(op);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      op_sel = op;
   endtask

   task automatic test_empty_sets();
      send_item(sud_pkg::ACT_COMPUTE, random_word());
   endtask

   task automatic test_extreme_values();
      sud_pkg::word_type a_vals [6] = '{sud_pkg::word_type'(32'h8000_0000),
                                        sud_pkg::word_type'(32'h7fff_ffff), '0, '1,
                                        sud_pkg::word_type'(32'h7fff_ffff),
                                        sud_pkg::word_type'(32'h5555_5555)};
      sud_pkg::word_type b_vals [4] = '{'1, sud_pkg::word_type'(32'haaaa_aaaa),
                                        sud_pkg::word_type'(32'h8000_0000), '1};
      send_item(sud_pkg::ACT_CLEAR, sud_pkg::word_type'(32'h7fff_ffff));
      foreach (a_vals[i]) send_item(sud_pkg::ACT_LOAD_A, a_vals[i]);
      foreach (b_vals[i]) send_item(sud_pkg::ACT_LOAD_B, b_vals[i]);
      send_item(sud_pkg::ACT_COMPUTE, '1);
   endtask

   task automatic test_operations();
      logic [1:0] ops [3] = '{sud_pkg::OP_INTERSECT, sud_pkg::OP_DIFFERENCE, OP_UNUSED};
      foreach (ops[i]) begin
         change_operation(ops[i]);
         send_item(sud_pkg::ACT_COMPUTE, random_word());
      end
      change_operation(sud_pkg::OP_UNION);
   endtask

   task automatic test_clear();
      send_item(sud_pkg::ACT_CLEAR, random_word());
      send_item(sud_pkg::ACT_COMPUTE, random_word());
   endtask

   // Most sequences are an optional clear, interleaved loads mostly drawn from a shared
   // pool so that the sets overlap, and a compute; a few are runs of arbitrary actions.
   task automatic test_random_sequences();
      sud_pkg::word_type pool [6];
      int                first_item;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) change_operation(2'($urandom_range(0, 3)));
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4))
               send_item(sud_pkg::action_type'($urandom_range(0, 3)), random_word());
         end else begin
            foreach (pool[i]) pool[i] = random_word();
            if ($urandom_range(0, 4) != 0) send_item(sud_pkg::ACT_CLEAR, random_word());
            repeat ($urandom_range(0, 20))
               send_item($urandom_range(0, 1) ? sud_pkg::ACT_LOAD_A : sud_pkg::ACT_LOAD_B,
                         ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 5)] :
                                                       random_word());
            send_item(sud_pkg::ACT_COMPUTE, random_word());
         end
      end
   endtask

   task automatic test_backpressure();
      change_operation(sud_pkg::OP_UNION);
      holds_asked++;
      send_item(sud_pkg::ACT_CLEAR, random_word());
      repeat (10) send_item(sud_pkg::ACT_LOAD_A, random_word());
      repeat (10) send_item(sud_pkg::ACT_LOAD_B, random_word());
      send_item(sud_pkg::ACT_COMPUTE, random_word());
      repeat (3) begin
         send_item(sud_pkg::ACT_LOAD_A, random_word());
         send_item(sud_pkg::ACT_COMPUTE, random_word());
      end
   endtask

   task automatic test_overflow();
      sud_pkg::word_type b_first;
      change_operation(sud_pkg::OP_UNION);
      send_item(sud_pkg::ACT_CLEAR, random_word());
      for (int i = 0; i < sud_pkg::SET_DEPTH; i++)
         send_item(sud_pkg::ACT_LOAD_A, sud_pkg::word_type'({8'(i), 24'($urandom)}));
      b_first = sud_pkg::word_type'({8'h80, 24'($urandom)});
      send_item(sud_pkg::ACT_LOAD_B, b_first);
      for (int i = 1; i < sud_pkg::SET_DEPTH; i++)
         send_item(sud_pkg::ACT_LOAD_B,
                   sud_pkg::word_type'({8'(8'h80 + i), 24'($urandom)}));
      send_item(sud_pkg::ACT_LOAD_B, b_first);
      send_item(sud_pkg::ACT_LOAD_A, sud_pkg::word_type'({8'h40, 24'($urandom)}));
      send_item(sud_pkg::ACT_LOAD_B, sud_pkg::word_type'({8'h41, 24'($urandom)}));
      send_item(sud_pkg::ACT_COMPUTE, random_word());
      change_operation(sud_pkg::OP_INTERSECT);
      send_item(sud_pkg::ACT_COMPUTE, random_word());
      send_item(sud_pkg::ACT_CLEAR, random_word());
      send_item(sud_pkg::ACT_COMPUTE, random_word());
   endtask

   // The receiver follows a stall pattern of its own and takes one long hold-off
   // whenever a test asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         rsp.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(8, 80);
         end
         mode_left--;
         case (rx_mode)
            RX_STEADY: rsp.ready <= 1'b1;
            RX_RANDOM: rsp.ready <= 1'($urandom_range(0, 1));
            default:   rsp.ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      element_beat_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat: value %0d present %b last %b overflowed %b",
                     $time, rsp.result_value, rsp.present, rsp.last, rsp.overflowed);
            mismatches++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp.result_value !== want.value || rsp.present !== want.present ||
                rsp.last !== want.last || rsp.overflowed !== want.overflowed) begin
               $display("%0t: expected value %0d present %b last %b overflowed %b", $time,
                        want.value, want.present, want.last, want.overflowed);
               $display("%0t: actual   value %0d present %b last %b overflowed %b", $time,
                        rsp.result_value, rsp.present, rsp.last, rsp.overflowed);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.action  <= sud_pkg::ACT_CLEAR;
      req.value   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_sets();
      test_extreme_values();
      test_operations();
      test_clear();
      test_random_sequences();
      test_backpressure();
      test_overflow();
      drain_results();
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
